### sv/qps_pkg.sv
// ----------------------------------------------------------------------------
// qps_pkg
// Shared types, codes and sizes of the queued playback sequencer.
// ----------------------------------------------------------------------------
package qps_pkg;

    // request queue sizing
    localparam int Q_DEPTH = 8;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // field widths
    localparam int OP_W    = 2;
    localparam int CMD_W   = 3;
    localparam int TRACK_W = 14;
    localparam int VOL_W   = 5;
    localparam int COL_W   = 8;
    localparam int TICK_W  = 24;
    localparam int WAIT_W  = 16;

    // stream widths (tdata padded to whole bytes)
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    // configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // saturation limits
    localparam logic [TRACK_W-1:0] TRACK_MAX  = 14'd9999;
    localparam logic [VOL_W-1:0]   VOLUME_MAX = 5'd30;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_BOOT_WAIT    = 2'd0;
    localparam logic [1:0] REG_COMMAND_WAIT = 2'd1;
    localparam logic [1:0] REG_PLAY_TIMEOUT = 2'd2;
    localparam logic [1:0] REG_GAP_DELAY    = 2'd3;

    // request opcodes
    localparam logic [OP_W-1:0] OP_TICK     = 2'd0;
    localparam logic [OP_W-1:0] OP_ENQUEUE  = 2'd1;
    localparam logic [OP_W-1:0] OP_FINISHED = 2'd2;

    // player commands
    localparam logic [CMD_W-1:0] CMD_NONE      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POWER_ON  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SET_VOL   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PLAY      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_STOP      = 3'd4;
    localparam logic [CMD_W-1:0] CMD_POWER_OFF = 3'd5;

    // controller phases, one-hot
    typedef enum logic [9:0] {
        PH_IDLE      = 10'b00_0000_0001,
        PH_TURN_ON   = 10'b00_0000_0010,
        PH_BOOT      = 10'b00_0000_0100,
        PH_SET_VOL   = 10'b00_0000_1000,
        PH_CMD       = 10'b00_0001_0000,
        PH_PLAY      = 10'b00_0010_0000,
        PH_WAIT_PLAY = 10'b00_0100_0000,
        PH_CHECK     = 10'b00_1000_0000,
        PH_GAP       = 10'b01_0000_0000,
        PH_TURN_OFF  = 10'b10_0000_0000
    } t_phase;

    // one queue entry
    typedef struct packed {
        logic [COL_W-1:0]   blue;
        logic [COL_W-1:0]   green;
        logic [COL_W-1:0]   red;
        logic [VOL_W-1:0]   volume;
        logic [TRACK_W-1:0] track;
    } t_entry;

    // control part of a result, waiting for the queue read data
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             dropped;
        logic             busy;
    } t_ctrl;

    // complete result
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic               busy;
        logic               dropped;
        logic [COL_W-1:0]   blue;
        logic [COL_W-1:0]   green;
        logic [COL_W-1:0]   red;
        logic [VOL_W-1:0]   volume;
        logic [TRACK_W-1:0] track;
    } t_result;

    // wrap-around pointer increment
    function automatic logic [Q_PTR_W-1:0] next_ptr(input logic [Q_PTR_W-1:0] p);
        logic [Q_PTR_W-1:0] r;
        r = (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

endpackage

### sv/queued_playback_sequencer_unit.sv
// ----------------------------------------------------------------------------
// queued_playback_sequencer_unit
// Playback sequencer for a serial audio player with a request queue.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser = opcode (tick, enqueue, finished event), tdata =
//   track, volume, red, green, blue. Every accepted request gives exactly one
//   result on the master stream: tuser = command, tdata = track, volume,
//   colour levels, dropped flag and busy status.
//   Enqueue requests go to an 8-entry queue held in a synchronous RAM;
//   ticks step the controller, which reads the head entry for the set volume
//   and play commands. The RAM read is registered in the read stage with the
//   control part, and the result then passes through the result queue to
//   o_m_tvalid. One request is taken every cycle while o_s_tready is high.
//   Up to three results are buffered (one read stage, two output slots);
//   while the receiver stalls with all three full, o_s_tready is low.
//   o_s_tready depends on registers only.
//   Reset (synchronous, active low) idles the controller, empties the queue
//   and loads the register defaults; the queue RAM itself is not cleared and
//   needs no clearing pass. The user must write registers over the APB port
//   only while no request is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module queued_playback_sequencer_unit
    import qps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // [13:0] track, [18:14] volume, [26:19] red, [34:27] green, [42:35] blue
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    // [1:0] opcode
    input  logic [OP_W-1:0]       i_s_tuser,
    // result stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [13:0] out_track, [18:14] out_volume, [26:19] out_red, [34:27] out_green,
    // [42:35] out_blue, [43] dropped, [44] busy_res
    output logic [M_TDATA_W-1:0]  o_m_tdata,
    // [2:0] command
    output logic [CMD_W-1:0]      o_m_tuser,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int OQ_DEPTH = 2;
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    // configuration registers
    logic [WAIT_W-1:0] r_boot_wait;
    logic [WAIT_W-1:0] r_command_wait;
    logic [TICK_W-1:0] r_play_timeout;
    logic [WAIT_W-1:0] r_gap_delay;

    // controller state
    t_phase             r_phase, n_phase;
    logic [Q_PTR_W-1:0] r_head, n_head;
    logic [Q_PTR_W-1:0] r_tail, n_tail;
    logic [Q_CNT_W-1:0] r_count, n_count;
    logic [TICK_W-1:0]  r_elapsed, n_elapsed;
    logic               r_finished, n_finished;
    logic               r_armed, n_armed;

    // queue RAM
    t_entry             r_mem [Q_DEPTH];
    t_entry             r_rd_entry;
    logic               wr_en;
    t_entry             wr_entry;

    // read stage
    logic               r_a_valid;
    t_ctrl              r_a_ctrl, n_a_ctrl;

    // result queue
    t_result            r_oq [OQ_DEPTH];
    logic               r_oq_wp, r_oq_rp;
    logic [OQ_CNT_W-1:0] r_oq_cnt;
    t_result            a_result;

    logic               s_fire, m_fire, a_push, cfg_wr;
    logic [TICK_W-1:0]  elapsed_inc, limit;
    logic               t_done;
    logic [TRACK_W-1:0] in_track;
    logic [VOL_W-1:0]   in_vol;

    assign s_fire     = i_s_tvalid && o_s_tready;
    assign m_fire     = o_m_tvalid && i_m_tready;
    assign o_s_tready = !(r_a_valid && (r_oq_cnt == OQ_CNT_W'(OQ_DEPTH)));
    assign a_push     = r_a_valid && (r_oq_cnt != OQ_CNT_W'(OQ_DEPTH));

    // APB register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[3:2])
            REG_BOOT_WAIT:    prdata = APB_DATA_W'(r_boot_wait);
            REG_COMMAND_WAIT: prdata = APB_DATA_W'(r_command_wait);
            REG_PLAY_TIMEOUT: prdata = APB_DATA_W'(r_play_timeout);
            REG_GAP_DELAY:    prdata = APB_DATA_W'(r_gap_delay);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boot_wait    <= 16'd1000;
            r_command_wait <= 16'd100;
            r_play_timeout <= 24'd600000;
            r_gap_delay    <= 16'd500;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_BOOT_WAIT:    r_boot_wait    <= pwdata[WAIT_W-1:0];
                REG_COMMAND_WAIT: r_command_wait <= pwdata[WAIT_W-1:0];
                REG_PLAY_TIMEOUT: r_play_timeout <= pwdata[TICK_W-1:0];
                REG_GAP_DELAY:    r_gap_delay    <= pwdata[WAIT_W-1:0];
                default: ;
            endcase
        end
    end

    // saturated enqueue fields
    assign in_track = i_s_tdata[13:0];
    assign in_vol   = i_s_tdata[18:14];

    always_comb begin
        wr_entry.track  = (in_track > TRACK_MAX) ? TRACK_MAX : in_track;
        wr_entry.volume = (in_vol > VOLUME_MAX) ? VOLUME_MAX : in_vol;
        wr_entry.red    = i_s_tdata[26:19];
        wr_entry.green  = i_s_tdata[34:27];
        wr_entry.blue   = i_s_tdata[42:35];
    end

    // wait timer: saturating increment and one compare against the phase limit
    assign elapsed_inc = (r_elapsed == '1) ? r_elapsed : r_elapsed + 1'b1;

    always_comb begin
        case (r_phase)
            PH_BOOT:      limit = TICK_W'(r_boot_wait);
            PH_CMD:       limit = TICK_W'(r_command_wait);
            PH_WAIT_PLAY: limit = r_play_timeout;
            default:      limit = TICK_W'(r_gap_delay);
        endcase
    end

    assign t_done = elapsed_inc >= limit;

    // controller next state for one request
    always_comb begin
        n_phase    = r_phase;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_elapsed  = r_elapsed;
        n_finished = r_finished;
        n_armed    = r_armed;
        n_a_ctrl   = '0;
        wr_en      = 1'b0;

        if (i_s_tuser == OP_ENQUEUE) begin
            if (r_count >= Q_CNT_W'(Q_DEPTH)) begin
                n_a_ctrl.dropped = 1'b1;
            end else begin
                wr_en   = 1'b1;
                n_tail  = next_ptr(r_tail);
                n_count = r_count + 1'b1;
            end
        end else if (i_s_tuser == OP_FINISHED) begin
            if (r_armed) begin
                n_finished = 1'b1;
            end
        end else if (i_s_tuser == OP_TICK) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (r_count != '0) begin
                        n_phase = PH_TURN_ON;
                    end
                end
                PH_TURN_ON: begin
                    n_a_ctrl.cmd = CMD_POWER_ON;
                    n_elapsed    = '0;
                    n_phase      = PH_BOOT;
                end
                PH_BOOT: begin
                    n_elapsed = elapsed_inc;
                    if (t_done) begin
                        n_phase = PH_SET_VOL;
                    end
                end
                PH_SET_VOL: begin
                    if (r_count == '0) begin
                        n_phase = PH_TURN_OFF;
                    end else begin
                        n_a_ctrl.cmd = CMD_SET_VOL;
                        n_elapsed    = '0;
                        n_phase      = PH_CMD;
                    end
                end
                PH_CMD: begin
                    n_elapsed = elapsed_inc;
                    if (t_done) begin
                        n_phase = PH_PLAY;
                    end
                end
                PH_PLAY: begin
                    if (r_count == '0) begin
                        n_phase = PH_TURN_OFF;
                    end else begin
                        n_finished   = 1'b0;
                        n_armed      = 1'b1;
                        n_a_ctrl.cmd = CMD_PLAY;
                        n_head       = next_ptr(r_head);
                        n_count      = r_count - 1'b1;
                        n_elapsed    = '0;
                        n_phase      = PH_WAIT_PLAY;
                    end
                end
                PH_WAIT_PLAY: begin
                    n_elapsed = elapsed_inc;
                    if (r_finished) begin
                        n_finished = 1'b0;
                        n_phase    = PH_CHECK;
                    end
                    // timeout wins the command even when finished came too
                    if (t_done) begin
                        n_a_ctrl.cmd = CMD_STOP;
                        n_phase      = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    if (r_count != '0) begin
                        n_elapsed = '0;
                        n_phase   = PH_GAP;
                    end else begin
                        n_phase = PH_TURN_OFF;
                    end
                end
                PH_GAP: begin
                    n_elapsed = elapsed_inc;
                    if (t_done) begin
                        n_finished = 1'b0;
                        n_phase    = PH_SET_VOL;
                    end
                end
                PH_TURN_OFF: begin
                    n_a_ctrl.cmd = CMD_POWER_OFF;
                    n_armed      = 1'b0;
                    n_finished   = 1'b0;
                    n_phase      = PH_IDLE;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end

        n_a_ctrl.busy = (n_phase != PH_IDLE);
    end

    // controller registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
            r_elapsed  <= '0;
            r_finished <= 1'b0;
            r_armed    <= 1'b0;
        end else if (s_fire) begin
            r_phase    <= n_phase;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_count    <= n_count;
            r_elapsed  <= n_elapsed;
            r_finished <= n_finished;
            r_armed    <= n_armed;
        end
    end

    // queue RAM: write at tail, registered read at head
    always_ff @(posedge i_clk) begin
        if (s_fire && wr_en) begin
            r_mem[r_tail] <= wr_entry;
        end
        if (s_fire) begin
            r_rd_entry <= r_mem[r_head];
        end
    end

    // read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (s_fire) begin
            r_a_valid <= 1'b1;
        end else if (a_push) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_a_ctrl <= n_a_ctrl;
        end
    end

    // merge control with head entry data
    always_comb begin
        a_result.cmd     = r_a_ctrl.cmd;
        a_result.busy    = r_a_ctrl.busy;
        a_result.dropped = r_a_ctrl.dropped;
        a_result.track   = '0;
        a_result.volume  = '0;
        a_result.red     = '0;
        a_result.green   = '0;
        a_result.blue    = '0;
        if (r_a_ctrl.cmd == CMD_PLAY) begin
            a_result.track = r_rd_entry.track;
        end
        if (r_a_ctrl.cmd == CMD_SET_VOL) begin
            a_result.volume = r_rd_entry.volume;
            a_result.red    = r_rd_entry.red;
            a_result.green  = r_rd_entry.green;
            a_result.blue   = r_rd_entry.blue;
        end
    end

    // two-slot result queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wp  <= 1'b0;
            r_oq_rp  <= 1'b0;
            r_oq_cnt <= '0;
        end else begin
            if (a_push) begin
                r_oq_wp <= !r_oq_wp;
            end
            if (m_fire) begin
                r_oq_rp <= !r_oq_rp;
            end
            case ({a_push, m_fire})
                2'b10:   r_oq_cnt <= r_oq_cnt + 1'b1;
                2'b01:   r_oq_cnt <= r_oq_cnt - 1'b1;
                default: r_oq_cnt <= r_oq_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_push) begin
            r_oq[r_oq_wp] <= a_result;
        end
    end

    // result stream
    assign o_m_tvalid = (r_oq_cnt != '0);
    assign o_m_tuser  = r_oq[r_oq_rp].cmd;
    assign o_m_tdata  = {3'b000, r_oq[r_oq_rp].busy, r_oq[r_oq_rp].dropped,
                         r_oq[r_oq_rp].blue, r_oq[r_oq_rp].green, r_oq[r_oq_rp].red,
                         r_oq[r_oq_rp].volume, r_oq[r_oq_rp].track};

endmodule

### sv/qps_chk.sv
// ----------------------------------------------------------------------------
// qps_chk
// Port-level checks of the queued playback sequencer result stream.
// ----------------------------------------------------------------------------
module qps_chk
    import qps_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [M_TDATA_W-1:0] o_m_tdata,
    input logic [CMD_W-1:0]     o_m_tuser
);

    // a held result stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result withdrawn while stalled");

    // power off always leaves the controller idle, power on never does
    a_power_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == CMD_POWER_OFF) |-> !o_m_tdata[44])
        else $error("busy after power off");

    a_on_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == CMD_POWER_ON) |-> o_m_tdata[44])
        else $error("idle after power on");

    // a dropped enqueue carries no command
    a_drop_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[43] |-> (o_m_tuser == CMD_NONE))
        else $error("command on a dropped enqueue");

    // track only with play, and saturated
    a_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[13:0] != '0) |->
            (o_m_tuser == CMD_PLAY) && (o_m_tdata[13:0] <= TRACK_MAX))
        else $error("bad track field");

endmodule

bind queued_playback_sequencer_unit qps_chk u_qps_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
